/* rtl/cgt_pkg.sv */
// Shared types, codes and field widths for the color gradient table.
package cgt_pkg;

    localparam int POS_W  = 17;
    localparam int COL_W  = 18;
    localparam int ID_W   = 16;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 3;
    localparam int RES_W  = 11;
    localparam int ENT_W  = 16;
    localparam int DIV_N  = COL_W + 32;

    localparam logic [RES_W-1:0] RES_RESET = 11'd256;

    localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REM_ID  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REM_POS = 3'd2;
    localparam logic [REQ_W-1:0] REQ_BUILD   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LOOKUP  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_KNOTS  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_BUILT = 3'd4;

    localparam logic [1:0] RES_PLAIN = 2'd0;
    localparam logic [1:0] RES_ADD   = 2'd1;
    localparam logic [1:0] RES_REM   = 2'd2;
    localparam logic [1:0] RES_LOOK  = 2'd3;

    typedef struct packed {
        logic              latch;
        logic              k_clr;
        logic              k_inc;
        logic              add_ins;
        logic              rem_do;
        logic              clr;
        logic              b_init;
        logic              b_thr;
        logic              b_adv;
        logic              b_fetch;
        logic              b_den;
        logic              b_div;
        logic              b_slope;
        logic              b_zero_slope;
        logic              b_wr;
        logic              b_acc;
        logic              l_mul;
        logic              emit;
        logic [1:0]        kind;
        logic [STAT_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             empty;
        logic             no_table;
        logic             k_end;
        logic             add_stop;
        logic             match;
        logic             b_step;
        logic             b_more;
        logic             b_last;
        logic             div_done;
    } t_stat;

endpackage

/* rtl/color_gradient_table_unit.sv */
// Top level of the piecewise-linear colormap engine.
// One request at a time; busy holds until the strobe, and the next start is taken in that cycle.
// Clear, full, no knots, not built and unknown requests end at decode; add/remove scan the knots
// one by one (up to MAX_KNOTS); a lookup passes a multiply and a RAM read before its strobe.
// A build writes each of its N entries and runs the 50-step slope divider for each of its S segments.
// Synchronous reset clears knot count, id counter and built size and sets resolution to 256.
module color_gradient_table_unit #(
    parameter int MAX_KNOTS   = 16,
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_we,
    input  logic [cgt_pkg::RES_W-1:0]         i_cfg_wdata,
    input  logic [cgt_pkg::REQ_W-1:0]         i_req_type,
    input  logic [cgt_pkg::POS_W-1:0]         i_position,
    input  logic signed [cgt_pkg::COL_W-1:0]  i_knot_red,
    input  logic signed [cgt_pkg::COL_W-1:0]  i_knot_green,
    input  logic signed [cgt_pkg::COL_W-1:0]  i_knot_blue,
    input  logic [cgt_pkg::ID_W-1:0]          i_target_id,
    output logic                              o_result_valid,
    output logic [cgt_pkg::STAT_W-1:0]        o_status,
    output logic [cgt_pkg::ID_W-1:0]          o_knot_id,
    output logic [cgt_pkg::POS_W-1:0]         o_knot_position,
    output logic signed [cgt_pkg::COL_W-1:0]  o_red,
    output logic signed [cgt_pkg::COL_W-1:0]  o_green,
    output logic signed [cgt_pkg::COL_W-1:0]  o_blue
);
    import cgt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cgt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cgt_dpath #(
        .MAX_KNOTS   (MAX_KNOTS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_type      (i_req_type),
        .i_position      (i_position),
        .i_knot_red      (i_knot_red),
        .i_knot_green    (i_knot_green),
        .i_knot_blue     (i_knot_blue),
        .i_target_id     (i_target_id),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_knot_id       (o_knot_id),
        .o_knot_position (o_knot_position),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue)
    );
endmodule

/* rtl/cgt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cgt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/cgt_ctrl.sv */
// Request sequencer: decodes requests and steps the datapath through each one.
module cgt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  cgt_pkg::t_stat i_stat,
    output cgt_pkg::t_cmd  o_cmd
);
    import cgt_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_ADD_SCAN = 4'd2;
    localparam logic [3:0] S_REM_SCAN = 4'd3;
    localparam logic [3:0] S_B_THR    = 4'd4;
    localparam logic [3:0] S_B_ENTRY  = 4'd5;
    localparam logic [3:0] S_B_FETCH  = 4'd6;
    localparam logic [3:0] S_B_DEN    = 4'd7;
    localparam logic [3:0] S_B_DIV    = 4'd8;
    localparam logic [3:0] S_B_SLOPE  = 4'd9;
    localparam logic [3:0] S_B_ACC    = 4'd10;
    localparam logic [3:0] S_L_RD     = 4'd11;
    localparam logic [3:0] S_L_OUT    = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       c;

    always_comb begin
        n_state = r_state;
        c       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    c.latch = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.req)
                    REQ_ADD: begin
                        if (i_stat.full) begin
                            c.emit   = 1'b1;
                            c.status = ST_FULL;
                            n_state  = S_IDLE;
                        end else begin
                            c.k_clr = 1'b1;
                            n_state = S_ADD_SCAN;
                        end
                    end
                    REQ_REM_ID, REQ_REM_POS: begin
                        c.k_clr = 1'b1;
                        n_state = S_REM_SCAN;
                    end
                    REQ_BUILD: begin
                        if (i_stat.empty) begin
                            c.emit   = 1'b1;
                            c.status = ST_NO_KNOTS;
                            n_state  = S_IDLE;
                        end else begin
                            c.b_init = 1'b1;
                            n_state  = S_B_THR;
                        end
                    end
                    REQ_LOOKUP: begin
                        if (i_stat.no_table) begin
                            c.emit   = 1'b1;
                            c.status = ST_NOT_BUILT;
                            n_state  = S_IDLE;
                        end else begin
                            c.l_mul = 1'b1;
                            n_state = S_L_RD;
                        end
                    end
                    REQ_CLEAR: begin
                        c.clr   = 1'b1;
                        c.emit  = 1'b1;
                        n_state = S_IDLE;
                    end
                    default: begin
                        c.emit  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ADD_SCAN: begin
                if (i_stat.add_stop) begin
                    c.add_ins = 1'b1;
                    c.emit    = 1'b1;
                    c.kind    = RES_ADD;
                    n_state   = S_IDLE;
                end else begin
                    c.k_inc = 1'b1;
                end
            end
            S_REM_SCAN: begin
                if (i_stat.k_end) begin
                    c.emit   = 1'b1;
                    c.status = ST_NOT_FOUND;
                    n_state  = S_IDLE;
                end else if (i_stat.match) begin
                    c.rem_do = 1'b1;
                    c.emit   = 1'b1;
                    c.kind   = RES_REM;
                    n_state  = S_IDLE;
                end else begin
                    c.k_inc = 1'b1;
                end
            end
            S_B_THR: begin
                c.b_thr = 1'b1;
                n_state = S_B_ENTRY;
            end
            S_B_ENTRY: begin
                c.b_wr = 1'b1;
                if (i_stat.b_step && i_stat.b_more) begin
                    c.b_adv = 1'b1;
                    n_state = S_B_FETCH;
                end else begin
                    c.b_zero_slope = i_stat.b_step;
                    c.b_acc        = 1'b1;
                    if (i_stat.b_last) begin
                        c.emit  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_B_FETCH: begin
                c.b_fetch = 1'b1;
                n_state   = S_B_DEN;
            end
            S_B_DEN: begin
                c.b_den = 1'b1;
                n_state = S_B_DIV;
            end
            S_B_DIV: begin
                c.b_div = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_B_SLOPE;
                end
            end
            S_B_SLOPE: begin
                c.b_slope = 1'b1;
                n_state   = S_B_ACC;
            end
            S_B_ACC: begin
                c.b_acc = 1'b1;
                if (i_stat.b_last) begin
                    c.emit  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_B_ENTRY;
                end
            end
            S_L_RD: begin
                n_state = S_L_OUT;
            end
            S_L_OUT: begin
                c.emit  = 1'b1;
                c.kind  = RES_LOOK;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = c;

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c.emit |=> r_state == S_IDLE)
        else $error("result emitted without returning to idle");
    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c.emit |=> !c.emit)
        else $error("two results for one request");
    a_latch_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c.latch |=> r_state == S_DECODE)
        else $error("accepted request not decoded");
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B_DIV && !i_stat.div_done) |=> r_state == S_B_DIV)
        else $error("divider left early");
endmodule

/* rtl/cgt_dpath.sv */
// Datapath: knot store, build interpolator with serial divider, table and lookup.
module cgt_dpath #(
    parameter int MAX_KNOTS   = 16,
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cgt_pkg::t_cmd                     i_cmd,
    output cgt_pkg::t_stat                    o_stat,
    input  logic                              i_cfg_we,
    input  logic [cgt_pkg::RES_W-1:0]         i_cfg_wdata,
    input  logic [cgt_pkg::REQ_W-1:0]         i_req_type,
    input  logic [cgt_pkg::POS_W-1:0]         i_position,
    input  logic signed [cgt_pkg::COL_W-1:0]  i_knot_red,
    input  logic signed [cgt_pkg::COL_W-1:0]  i_knot_green,
    input  logic signed [cgt_pkg::COL_W-1:0]  i_knot_blue,
    input  logic [cgt_pkg::ID_W-1:0]          i_target_id,
    output logic                              o_result_valid,
    output logic [cgt_pkg::STAT_W-1:0]        o_status,
    output logic [cgt_pkg::ID_W-1:0]          o_knot_id,
    output logic [cgt_pkg::POS_W-1:0]         o_knot_position,
    output logic signed [cgt_pkg::COL_W-1:0]  o_red,
    output logic signed [cgt_pkg::COL_W-1:0]  o_green,
    output logic signed [cgt_pkg::COL_W-1:0]  o_blue
);
    import cgt_pkg::*;

    localparam int KW     = $clog2(MAX_KNOTS);
    localparam int CNT_W  = KW + 1;
    localparam int EW     = $clog2(MAX_ENTRIES);
    localparam int BW     = EW + 1;
    localparam int THR_W  = POS_W + EW;
    localparam int CW     = (BW > RES_W) ? BW : RES_W;
    localparam int DCNT_W = $clog2(DIV_N);
    localparam int ACC_W  = 64;

    localparam logic signed [ACC_W-1:0] ACC_LIM = 64'sh1000_0000_0000_0000;

    function automatic logic [ENT_W-1:0] to_entry(input logic signed [ACC_W-1:0] a);
        logic [ENT_W-1:0] v;
        v = '0;
        if (a <= 0) begin
            v = '0;
        end else if ((a[62:32] != '0) || (a[31:16] == 16'hFFFF)) begin
            v = 16'hFFFF;
        end else begin
            v = a[31:16];
        end
        return v;
    endfunction

    // knot store
    logic [POS_W-1:0]        r_kpos [MAX_KNOTS];
    logic [ID_W-1:0]         r_kid  [MAX_KNOTS];
    logic signed [COL_W-1:0] r_kcol [MAX_KNOTS][3];
    logic [CNT_W-1:0]        r_count;
    logic [ID_W-1:0]         r_next_id;
    logic [BW-1:0]           r_built;
    logic [RES_W-1:0]        r_res;

    // request latch
    logic [REQ_W-1:0]        r_req;
    logic [POS_W-1:0]        r_pos;
    logic signed [COL_W-1:0] r_cin [3];
    logic [ID_W-1:0]         r_tid;

    // scan / build pointers
    logic [CNT_W-1:0]        r_k;
    logic [EW-1:0]           r_i;
    logic [BW-1:0]           r_bres;
    logic [THR_W-1:0]        r_thr;
    logic [THR_W-1:0]        r_den;
    logic [POS_W-1:0]        r_cur_pos;
    logic [POS_W-1:0]        r_nxt_pos;
    logic signed [COL_W-1:0] r_cur_col [3];
    logic signed [COL_W-1:0] r_nxt_col [3];
    logic signed [ACC_W-1:0] r_acc     [3];
    logic signed [ACC_W-1:0] r_slope   [3];
    logic [THR_W-1:0]        r_rem     [3];
    logic [DIV_N-1:0]        r_dq      [3];
    logic                    r_neg     [3];
    logic [DCNT_W-1:0]       r_dcnt;
    logic [THR_W-1:0]        r_lprod;

    logic [KW-1:0]           ka;
    logic [POS_W-1:0]        rd_pos;
    logic [ID_W-1:0]         rd_id;
    logic signed [COL_W-1:0] rd_col [3];
    logic [BW-1:0]           i1;
    logic [EW-1:0]           bres_m1;
    logic [EW-1:0]           built_m1;
    logic [CW-1:0]           resx;
    logic [BW-1:0]           bres_clamped;
    logic [BW-1:0]           lidx_raw;
    logic [EW-1:0]           raddr;
    logic [3*ENT_W-1:0]      ram_wdata;
    logic [3*ENT_W-1:0]      ram_rdata;

    assign ka     = r_k[KW-1:0];
    assign rd_pos = r_kpos[ka];
    assign rd_id  = r_kid[ka];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rd_col[c] = r_kcol[ka][c];
        end
    end

    assign i1       = BW'(r_i) + BW'(1);
    assign bres_m1  = EW'(r_bres - BW'(1));
    assign built_m1 = EW'(r_built - BW'(1));

    always_comb begin
        resx = CW'(r_res);
        if (resx < CW'(2)) begin
            bres_clamped = BW'(2);
        end else if (resx > CW'(MAX_ENTRIES)) begin
            bres_clamped = BW'(MAX_ENTRIES);
        end else begin
            bres_clamped = BW'(resx);
        end
    end

    // clamp lookup index to the last built entry
    assign lidx_raw = r_lprod[THR_W-1:16];
    assign raddr    = (lidx_raw >= r_built) ? built_m1 : lidx_raw[EW-1:0];

    always_comb begin
        o_stat.req      = r_req;
        o_stat.full     = (r_count == CNT_W'(MAX_KNOTS));
        o_stat.empty    = (r_count == '0);
        o_stat.no_table = (r_built == '0);
        o_stat.k_end    = (r_k == r_count);
        o_stat.add_stop = (r_k == r_count) || (rd_pos > r_pos);
        o_stat.match    = (r_req == REQ_REM_ID) ? (rd_id == r_tid) : (rd_pos == r_pos);
        o_stat.b_step   = ({i1, 16'b0} >= r_thr);
        o_stat.b_more   = ((r_k + CNT_W'(1)) < r_count);
        o_stat.b_last   = (i1 == r_bres);
        o_stat.div_done = (r_dcnt == DCNT_W'(DIV_N - 1));
    end

    assign ram_wdata = {to_entry(r_acc[0]), to_entry(r_acc[1]), to_entry(r_acc[2])};

    cgt_ram #(
        .WIDTH (3 * ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.b_wr),
        .i_waddr (r_i),
        .i_wdata (ram_wdata),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_next_id      <= '0;
            r_built        <= '0;
            r_res          <= RES_RESET;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.emit;
            if (i_cfg_we) begin
                r_res <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_count   <= '0;
                r_next_id <= '0;
                r_built   <= '0;
            end
            if (i_cmd.add_ins) begin
                r_count   <= r_count + CNT_W'(1);
                r_next_id <= r_next_id + ID_W'(1);
            end
            if (i_cmd.rem_do) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.b_acc && o_stat.b_last) begin
                r_built <= r_bres;
            end
        end
    end

    // knot store shifts: open a slot on insert, close it on removal
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_ins) begin
            for (int j = 1; j < MAX_KNOTS; j++) begin
                if (KW'(j) > ka) begin
                    r_kpos[j] <= r_kpos[j-1];
                    r_kid[j]  <= r_kid[j-1];
                    for (int c = 0; c < 3; c++) begin
                        r_kcol[j][c] <= r_kcol[j-1][c];
                    end
                end
            end
            r_kpos[ka] <= r_pos;
            r_kid[ka]  <= r_next_id;
            for (int c = 0; c < 3; c++) begin
                r_kcol[ka][c] <= r_cin[c];
            end
        end
        if (i_cmd.rem_do) begin
            for (int j = 0; j < MAX_KNOTS - 1; j++) begin
                if (KW'(j) >= ka) begin
                    r_kpos[j] <= r_kpos[j+1];
                    r_kid[j]  <= r_kid[j+1];
                    for (int c = 0; c < 3; c++) begin
                        r_kcol[j][c] <= r_kcol[j+1][c];
                    end
                end
            end
        end
    end

    // request latch, scan pointer and build datapath
    always_ff @(posedge i_clk) begin
        logic signed [COL_W:0]   dc;
        logic [COL_W:0]          mag;
        logic [THR_W:0]          sh;
        logic signed [ACC_W-1:0] q;
        logic signed [ACC_W-1:0] sum;
        if (i_cmd.latch) begin
            r_req  <= i_req_type;
            r_pos  <= i_position;
            r_cin[0] <= i_knot_red;
            r_cin[1] <= i_knot_green;
            r_cin[2] <= i_knot_blue;
            r_tid  <= i_target_id;
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end
        if (i_cmd.k_inc || i_cmd.b_adv) begin
            r_k <= r_k + CNT_W'(1);
        end
        if (i_cmd.b_init) begin
            r_k       <= '0;
            r_i       <= '0;
            r_bres    <= bres_clamped;
            r_nxt_pos <= r_kpos[0];
            for (int c = 0; c < 3; c++) begin
                r_nxt_col[c] <= r_kcol[0][c];
                r_slope[c]   <= '0;
                r_acc[c]     <= {{(ACC_W-COL_W-16){r_kcol[0][c][COL_W-1]}},
                                 r_kcol[0][c], 16'b0};
            end
        end
        if (i_cmd.b_thr) begin
            r_thr <= THR_W'(r_nxt_pos) * THR_W'(bres_m1);
        end
        if (i_cmd.b_fetch) begin
            r_cur_pos <= r_nxt_pos;
            r_nxt_pos <= rd_pos;
            for (int c = 0; c < 3; c++) begin
                r_cur_col[c] <= r_nxt_col[c];
                r_nxt_col[c] <= rd_col[c];
            end
        end
        if (i_cmd.b_den) begin
            r_den  <= THR_W'(r_nxt_pos - r_cur_pos) * THR_W'(bres_m1);
            r_thr  <= THR_W'(r_nxt_pos) * THR_W'(bres_m1);
            r_dcnt <= '0;
            for (int c = 0; c < 3; c++) begin
                dc  = {r_nxt_col[c][COL_W-1], r_nxt_col[c]}
                    - {r_cur_col[c][COL_W-1], r_cur_col[c]};
                mag = dc[COL_W] ? (COL_W+1)'(-dc) : (COL_W+1)'(dc);
                r_neg[c] <= dc[COL_W];
                r_rem[c] <= '0;
                r_dq[c]  <= {mag[COL_W-1:0], 32'b0};
            end
        end
        // one restoring quotient bit per cycle, three colors in parallel
        if (i_cmd.b_div) begin
            r_dcnt <= r_dcnt + DCNT_W'(1);
            for (int c = 0; c < 3; c++) begin
                sh = {r_rem[c], r_dq[c][DIV_N-1]};
                if (sh >= {1'b0, r_den}) begin
                    r_rem[c] <= THR_W'(sh - {1'b0, r_den});
                    r_dq[c]  <= {r_dq[c][DIV_N-2:0], 1'b1};
                end else begin
                    r_rem[c] <= sh[THR_W-1:0];
                    r_dq[c]  <= {r_dq[c][DIV_N-2:0], 1'b0};
                end
            end
        end
        if (i_cmd.b_slope) begin
            for (int c = 0; c < 3; c++) begin
                q = {{(ACC_W-DIV_N){1'b0}}, r_dq[c]};
                if (r_den == '0) begin
                    r_slope[c] <= '0;
                end else begin
                    r_slope[c] <= r_neg[c] ? -q : q;
                end
            end
        end
        if (i_cmd.b_zero_slope) begin
            for (int c = 0; c < 3; c++) begin
                r_slope[c] <= '0;
            end
        end
        if (i_cmd.b_acc) begin
            r_i <= EW'(i1);
            if (!i_cmd.b_zero_slope) begin
                for (int c = 0; c < 3; c++) begin
                    sum = r_acc[c] + r_slope[c];
                    if (sum > ACC_LIM) begin
                        r_acc[c] <= ACC_LIM;
                    end else if (sum < -ACC_LIM) begin
                        r_acc[c] <= -ACC_LIM;
                    end else begin
                        r_acc[c] <= sum;
                    end
                end
            end
        end
        if (i_cmd.l_mul) begin
            r_lprod <= THR_W'(r_pos) * THR_W'(built_m1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status        <= i_cmd.status;
            o_knot_id       <= '0;
            o_knot_position <= '0;
            o_red           <= '0;
            o_green         <= '0;
            o_blue          <= '0;
            case (i_cmd.kind)
                RES_ADD: begin
                    o_knot_id <= r_next_id;
                end
                RES_REM: begin
                    o_knot_id       <= rd_id;
                    o_knot_position <= rd_pos;
                    o_red           <= rd_col[0];
                    o_green         <= rd_col[1];
                    o_blue          <= rd_col[2];
                end
                RES_LOOK: begin
                    o_red   <= {2'b00, ram_rdata[3*ENT_W-1:2*ENT_W]};
                    o_green <= {2'b00, ram_rdata[2*ENT_W-1:ENT_W]};
                    o_blue  <= {2'b00, ram_rdata[ENT_W-1:0]};
                end
                default: begin
                end
            endcase
        end
    end
endmodule
